// ===== sv/slbi_pkg.sv =====
// Package for the status LED blink indicator: command and link codes,
// blink timing constants and the transaction payload types.
// No dependencies.
`timescale 1ns / 1ps

package slbi_pkg;

	// Command codes carried by each input transaction
	typedef enum logic [2:0] {
		CMD_TICK       = 3'd0,
		CMD_SET_ERROR  = 3'd1,
		CMD_SET_WARN   = 3'd2,
		CMD_SET_TEMP   = 3'd3,
		CMD_CLEAR_WARN = 3'd4
	} cmd_code_t;

	// Remote link states
	typedef enum logic [1:0] {
		LINK_NONE      = 2'd0,
		LINK_LOCKED    = 2'd1,
		LINK_UNLOCKING = 2'd2,
		LINK_UNLOCKED  = 2'd3
	} link_code_t;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SAFE_LOCK  = 1'd0,
		CFG_TEMP_TICKS = 1'd1
	} cfg_index_t;

	localparam int TICKS_W = 16;

	// Blink timing
	localparam logic [2:0] PRESCALE_LAST = 3'd4;  // divide by 5
	localparam logic [3:0] PHASE_LAST    = 4'd9;  // 10 phases
	localparam logic [3:0] SHORT_PHASES  = 4'd2;
	localparam logic [3:0] LONG_PHASES   = 4'd4;
	localparam logic [TICKS_W-1:0] TICKS_MAX = '1;

	// Configuration reset values
	localparam logic               SAFE_LOCK_RESET  = 1'b1;
	localparam logic [TICKS_W-1:0] TEMP_TICKS_RESET = 16'd40;

	typedef struct packed {
		logic [2:0] command;
		logic [1:0] link_state;
	} cmd_item_t;

	typedef struct packed {
		logic green_led;
		logic red_led;
		logic error_active;
		logic warning_active;
		logic temp_warning_active;
	} res_item_t;

endpackage

// ===== sv/status_led_blink_indicator.sv =====
// Status LED blink indicator: takes tick and flag commands, returns one
// LED and flag status per command. Depends on slbi_pkg.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd): one command per transaction, either
//   a tick with the remote link state or a set/clear of a status flag.
//   res channel (res_valid/res_ready/res): one result per command, carrying
//   the LED drives and the three flags as they stand after that command.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is the safe
//   lock mode, index 1 the temporary warning lifetime in ticks. Always ready;
//   write only while no command is in flight.
// Result: registered; res_valid rises in the cycle after its command is accepted.
// Throughput: one command per cycle while no result is stalled; the state update
//   and the result register are written at the same edge the command is accepted.
// Stall: while res_valid is high and res_ready is low, the result holds and
//   cmd_ready drops; a pending result that is taken in the same cycle lets a
//   new command in at once.
// Reset: flags, prescaler, blink phase, toggle and LEDs clear, safe lock mode
//   goes to 1, the lifetime to 40 ticks, and no result is pending.
`timescale 1ns / 1ps

module status_led_blink_indicator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cmd_valid,
	output logic                                 cmd_ready,
	input  slbi_pkg::cmd_item_t                  cmd,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output slbi_pkg::res_item_t                  res,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [slbi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [slbi_pkg::TICKS_W-1:0]         cfg_data
);
	import slbi_pkg::*;

	// Configuration and state registers
	logic               safe_lock_q;
	logic [TICKS_W-1:0] temp_ticks_q;
	logic               err_q, warn_q, temp_q;
	logic [2:0]         prescale_q;
	logic [3:0]         phase_q;
	logic               toggle_q;
	logic               green_q, red_q;
	logic [TICKS_W-1:0] since_temp_q;
	logic               res_valid_q;
	res_item_t          res_q;

	// Next-state values
	logic               err_d, warn_d, temp_d;
	logic [2:0]         prescale_d;
	logic [3:0]         phase_d;
	logic               toggle_d;
	logic               green_d, red_d;
	logic [TICKS_W-1:0] since_temp_d;
	logic [TICKS_W-1:0] since_inc;
	logic               toggles;
	logic               accept;

	assign cmd_ready = !res_valid_q || res_ready;
	assign accept    = cmd_valid && cmd_ready;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Decide whether the current phase toggles for this link state
	always_comb begin
		if (link_code_t'(cmd.link_state) == LINK_NONE) begin
			toggles = 1'b1;
		end else if (safe_lock_q && (link_code_t'(cmd.link_state) == LINK_LOCKED ||
				link_code_t'(cmd.link_state) == LINK_UNLOCKING)) begin
			toggles = phase_q < SHORT_PHASES;
		end else begin
			toggles = phase_q < LONG_PHASES;
		end
	end

	// Apply one command to the state
	always_comb begin
		err_d        = err_q;
		warn_d       = warn_q;
		temp_d       = temp_q;
		prescale_d   = prescale_q;
		phase_d      = phase_q;
		toggle_d     = toggle_q;
		green_d      = green_q;
		red_d        = red_q;
		since_temp_d = since_temp_q;
		since_inc    = (since_temp_q == TICKS_MAX) ? since_temp_q : since_temp_q + 1'b1;
		case (cmd_code_t'(cmd.command))
			CMD_TICK: begin
				if (prescale_q == 3'd0) begin
					if (phase_q == 4'd0) begin
						toggle_d = 1'b0;
						green_d  = 1'b0;
						red_d    = 1'b0;
					end
					if (toggles) begin
						toggle_d = !toggle_d;
						green_d  = toggle_d && !err_q;
						red_d    = toggle_d && (err_q || warn_q || temp_q);
					end
					phase_d = (phase_q == PHASE_LAST) ? 4'd0 : phase_q + 4'd1;
				end
				prescale_d   = (prescale_q == PRESCALE_LAST) ? 3'd0 : prescale_q + 3'd1;
				since_temp_d = since_inc;
				if (since_inc > temp_ticks_q) begin
					temp_d = 1'b0;
				end
			end
			CMD_SET_ERROR: err_d = 1'b1;
			CMD_SET_WARN:  warn_d = 1'b1;
			CMD_SET_TEMP: begin
				temp_d       = 1'b1;
				since_temp_d = '0;
			end
			CMD_CLEAR_WARN: begin
				warn_d = 1'b0;
				temp_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			safe_lock_q  <= SAFE_LOCK_RESET;
			temp_ticks_q <= TEMP_TICKS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_SAFE_LOCK:  safe_lock_q  <= cfg_data[0];
				CFG_TEMP_TICKS: temp_ticks_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Advance the state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q        <= 1'b0;
			warn_q       <= 1'b0;
			temp_q       <= 1'b0;
			prescale_q   <= '0;
			phase_q      <= '0;
			toggle_q     <= 1'b0;
			green_q      <= 1'b0;
			red_q        <= 1'b0;
			since_temp_q <= '0;
		end else if (accept) begin
			err_q        <= err_d;
			warn_q       <= warn_d;
			temp_q       <= temp_d;
			prescale_q   <= prescale_d;
			phase_q      <= phase_d;
			toggle_q     <= toggle_d;
			green_q      <= green_d;
			red_q        <= red_d;
			since_temp_q <= since_temp_d;
		end
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.green_led           <= green_d;
			res_q.red_led             <= red_d;
			res_q.error_active        <= err_d;
			res_q.warning_active      <= warn_d;
			res_q.temp_warning_active <= temp_d;
		end
	end

endmodule

// ===== sv/slbi_checker.sv =====
// Port-level checks for the status LED blink indicator, bound to its top level.
// Depends on slbi_pkg and status_led_blink_indicator.
`timescale 1ns / 1ps

module slbi_port_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 cmd_valid,
	input logic                                 cmd_ready,
	input logic                                 res_valid,
	input logic                                 res_ready,
	input slbi_pkg::res_item_t                  res
);
	import slbi_pkg::*;

	logic err_seen_q;

	// Remember whether any result has reported the error flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
		end else if (res_valid && res.error_active) begin
			err_seen_q <= 1'b1;
		end
	end

	// A stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// The error flag is only cleared by reset
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && err_seen_q |-> res.error_active)
		else $error("error flag dropped without reset");

	// With no result pending the block takes a command
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> cmd_ready)
		else $error("command stalled with empty result register");

	// Every accepted transaction yields a result in the next cycle
	a_res_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> res_valid)
		else $error("result missing after accepted command");

endmodule

bind status_led_blink_indicator slbi_port_checker u_slbi_checker (.*);
